// ----- sv/tsvg_pkg.sv -----
// Shared types, constants and a lookup function for the tube strip vertex generator.
package tsvg_pkg;

    localparam int SEG_W            = 8;
    localparam int MAX_SEGMENTS_DEF = 255;
    localparam int CORDIC_STEPS     = 16;
    localparam int ANG_W            = 32;
    localparam int DIV_STAGES       = 8;
    localparam int DIV_BITS         = ANG_W / DIV_STAGES;
    localparam int THETA_DELAY      = 9;
    localparam int VEC_LAT          = CORDIC_STEPS + 1;
    localparam int ROT_LAT          = CORDIC_STEPS + 2;
    localparam int CALC_LAT         = 2;
    localparam int PIPE_LAT         = VEC_LAT + ROT_LAT + CALC_LAT;
    localparam int MIN_SEGMENTS     = 3;

    typedef logic signed [15:0] q14_t;
    typedef logic signed [16:0] trig_t;
    typedef logic [ANG_W-1:0]   angle_t;
    typedef logic signed [33:0] cord_t;
    typedef q14_t [2:0]         vec3_t;

    localparam cord_t GAIN_Q30 = 34'sd652032874;
    localparam cord_t RND_Q16  = 34'sd32768;

    // Axis selector codes that move the axial coordinate off x
    localparam logic [1:0] AXIS_Y = 2'd2;
    localparam logic [1:0] AXIS_Z = 2'd3;

    // Register map indexes
    typedef enum logic [2:0] {
        REG_SEGMENTS,
        REG_AXIS_SELECT,
        REG_X_START,
        REG_R_START,
        REG_X_END,
        REG_R_END,
        REG_CENTER_Y,
        REG_CENTER_Z
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] axis_select;
        q14_t       x_start;
        q14_t       r_start;
        q14_t       x_end;
        q14_t       r_end;
        q14_t       center_y;
        q14_t       center_z;
    } cfg_t;

    // Arctangent of 2^-i in turns scaled by 2^32
    function automatic angle_t atan_turn(input int unsigned i);
        angle_t v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10680862;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/tsvg_theta_div.sv -----
// Pipelined long division giving theta = floor(j * 2^32 / segments) modulo 2^32.
module tsvg_theta_div (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [tsvg_pkg::SEG_W-1:0] segment_index,
    input  logic [tsvg_pkg::SEG_W-1:0] segments,
    output tsvg_pkg::angle_t         theta
);

    localparam int SW = tsvg_pkg::SEG_W;
    localparam int AW = tsvg_pkg::ANG_W;

    logic [SW-1:0]    rem_reg [tsvg_pkg::DIV_STAGES];
    tsvg_pkg::angle_t quo_reg [tsvg_pkg::DIV_STAGES];
    logic [SW-1:0]    rem0;

    // Drop the integer quotient bit; only the fraction matters modulo one turn
    assign rem0 = (segment_index >= segments) ? SW'(segment_index - segments) : segment_index;

    for (genvar s = 0; s < tsvg_pkg::DIV_STAGES; s++) begin : g_stage
        logic [SW-1:0]    rem_in;
        tsvg_pkg::angle_t quo_in;
        logic [SW-1:0]    rem_next;
        tsvg_pkg::angle_t quo_next;

        if (s == 0) begin : g_first
            assign rem_in = rem0;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        // Restoring division, a few quotient bits per stage
        always_comb begin
            logic [SW:0] t;
            rem_next = rem_in;
            quo_next = quo_in;
            for (int b = 0; b < tsvg_pkg::DIV_BITS; b++) begin
                t = {rem_next, 1'b0};
                if (t >= {1'b0, segments}) begin
                    rem_next = SW'(t - {1'b0, segments});
                    quo_next = {quo_next[AW-2:0], 1'b1};
                end else begin
                    rem_next = t[SW-1:0];
                    quo_next = {quo_next[AW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign theta = quo_reg[tsvg_pkg::DIV_STAGES-1];

endmodule

// ----- sv/tsvg_vec_cordic.sv -----
// Pipelined CORDIC in vectoring mode giving atan2(dr, dx) in turns.
module tsvg_vec_cordic (
    input  logic             aclk,
    input  logic             en,
    input  tsvg_pkg::cfg_t   cfg,
    output tsvg_pkg::angle_t angle
);

    localparam int N = tsvg_pkg::CORDIC_STEPS;

    tsvg_pkg::cord_t  x_reg [N+1];
    tsvg_pkg::cord_t  y_reg [N+1];
    tsvg_pkg::angle_t z_reg [N+1];

    logic signed [16:0] dx;
    logic signed [16:0] dr;
    tsvg_pkg::cord_t    dx_w;
    tsvg_pkg::cord_t    dr_w;

    assign dx   = $signed({cfg.x_end[15], cfg.x_end}) - $signed({cfg.x_start[15], cfg.x_start});
    assign dr   = $signed({cfg.r_end[15], cfg.r_end}) - $signed({cfg.r_start[15], cfg.r_start});
    assign dx_w = tsvg_pkg::cord_t'(dx) <<< 14;
    assign dr_w = tsvg_pkg::cord_t'(dr) <<< 14;

    // Pre-rotate by a half turn into the right half plane
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dx < 0) begin
                x_reg[0] <= -dx_w;
                y_reg[0] <= -dr_w;
                z_reg[0] <= {1'b1, {(tsvg_pkg::ANG_W-1){1'b0}}};
            end else begin
                x_reg[0] <= dx_w;
                y_reg[0] <= dr_w;
                z_reg[0] <= '0;
            end
        end
    end

    // Rotate towards y = 0, one step per stage
    for (genvar i = 0; i < N; i++) begin : g_step
        tsvg_pkg::cord_t tx;
        tsvg_pkg::cord_t ty;
        assign tx = y_reg[i] >>> i;
        assign ty = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + tx;
                    y_reg[i+1] <= y_reg[i] - ty;
                    z_reg[i+1] <= z_reg[i] + tsvg_pkg::atan_turn(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - tx;
                    y_reg[i+1] <= y_reg[i] + ty;
                    z_reg[i+1] <= z_reg[i] - tsvg_pkg::atan_turn(i);
                end
            end
        end
    end

    assign angle = z_reg[N];

endmodule

// ----- sv/tsvg_rot_cordic.sv -----
// Pipelined CORDIC in rotation mode giving sine and cosine in Q2.14.
module tsvg_rot_cordic (
    input  logic             aclk,
    input  logic             en,
    input  tsvg_pkg::angle_t angle,
    output tsvg_pkg::trig_t  sin_q,
    output tsvg_pkg::trig_t  cos_q
);

    localparam int N  = tsvg_pkg::CORDIC_STEPS;
    localparam int AW = tsvg_pkg::ANG_W;

    tsvg_pkg::cord_t       x_reg   [N+1];
    tsvg_pkg::cord_t       y_reg   [N+1];
    logic signed [AW:0]    a_reg   [N+1];
    logic                  neg_reg [N+1];
    tsvg_pkg::trig_t       sin_reg;
    tsvg_pkg::trig_t       cos_reg;

    logic             neg_in;
    tsvg_pkg::angle_t zr;
    tsvg_pkg::cord_t  xf;
    tsvg_pkg::cord_t  yf;

    // Fold the second and third quadrants by a half turn
    assign neg_in = (angle[AW-1:AW-2] == 2'd1) || (angle[AW-1:AW-2] == 2'd2);
    assign zr     = neg_in ? (angle - {1'b1, {(AW-1){1'b0}}}) : angle;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0]   <= (AW+1)'($signed(zr));
            x_reg[0]   <= tsvg_pkg::GAIN_Q30;
            y_reg[0]   <= '0;
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        tsvg_pkg::cord_t dx;
        tsvg_pkg::cord_t dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (a_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    a_reg[i+1] <= a_reg[i] - (AW+1)'(tsvg_pkg::atan_turn(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    a_reg[i+1] <= a_reg[i] + (AW+1)'(tsvg_pkg::atan_turn(i));
                end
            end
        end
    end

    // Undo the fold and round Q1.30 to Q2.14
    assign xf = neg_reg[N] ? -x_reg[N] : x_reg[N];
    assign yf = neg_reg[N] ? -y_reg[N] : y_reg[N];

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= tsvg_pkg::trig_t'((xf + tsvg_pkg::RND_Q16) >>> 16);
            sin_reg <= tsvg_pkg::trig_t'((yf + tsvg_pkg::RND_Q16) >>> 16);
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ----- sv/tsvg_vertex_calc.sv -----
// Ring vertex and normal arithmetic: products, offset, saturation and axis permutation.
module tsvg_vertex_calc (
    input  logic            aclk,
    input  logic            en,
    input  tsvg_pkg::cfg_t  cfg,
    input  tsvg_pkg::trig_t st,
    input  tsvg_pkg::trig_t ct,
    input  tsvg_pkg::trig_t sa,
    input  tsvg_pkg::trig_t ca,
    output tsvg_pkg::vec3_t pos0,
    output tsvg_pkg::vec3_t pos1,
    output tsvg_pkg::vec3_t nrm
);

    typedef logic signed [32:0] prod_t;
    typedef logic signed [19:0] sum_t;

    prod_t           rs_st_reg, rs_ct_reg, re_st_reg, re_ct_reg, st_ca_reg, ct_ca_reg;
    tsvg_pkg::trig_t sa_reg;
    tsvg_pkg::vec3_t pos0_reg, pos1_reg, nrm_reg;

    function automatic sum_t round14(input prod_t p);
        prod_t t;
        t = (p + 33'sd8192) >>> 14;
        return sum_t'(t);
    endfunction

    function automatic tsvg_pkg::q14_t sat16(input sum_t v);
        tsvg_pkg::q14_t r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic tsvg_pkg::vec3_t permute(input tsvg_pkg::q14_t ax,
                                                input tsvg_pkg::q14_t t1,
                                                input tsvg_pkg::q14_t t2,
                                                input logic [1:0]     sel);
        tsvg_pkg::vec3_t v;
        case (sel)
            tsvg_pkg::AXIS_Y: begin
                v[0] = t2; v[1] = ax; v[2] = t1;
            end
            tsvg_pkg::AXIS_Z: begin
                v[0] = t1; v[1] = t2; v[2] = ax;
            end
            default: begin
                v[0] = ax; v[1] = t1; v[2] = t2;
            end
        endcase
        return v;
    endfunction

    // Stage one: all six products in parallel
    always_ff @(posedge aclk) begin
        if (en) begin
            rs_st_reg <= $signed(cfg.r_start) * $signed(st);
            rs_ct_reg <= $signed(cfg.r_start) * $signed(ct);
            re_st_reg <= $signed(cfg.r_end) * $signed(st);
            re_ct_reg <= $signed(cfg.r_end) * $signed(ct);
            st_ca_reg <= $signed(st) * $signed(ca);
            ct_ca_reg <= $signed(ct) * $signed(ca);
            sa_reg    <= sa;
        end
    end

    sum_t neg_sa;
    sum_t cy_w, cz_w;
    assign neg_sa = -$signed({{3{sa_reg[16]}}, sa_reg});
    assign cy_w   = sum_t'($signed(cfg.center_y));
    assign cz_w   = sum_t'($signed(cfg.center_z));

    // Stage two: round, offset, saturate and permute
    always_ff @(posedge aclk) begin
        if (en) begin
            pos0_reg <= permute(cfg.x_start, sat16(cy_w + round14(rs_st_reg)),
                                sat16(cz_w + round14(rs_ct_reg)), cfg.axis_select);
            pos1_reg <= permute(cfg.x_end, sat16(cy_w + round14(re_st_reg)),
                                sat16(cz_w + round14(re_ct_reg)), cfg.axis_select);
            nrm_reg  <= permute(sat16(neg_sa), sat16(round14(st_ca_reg)),
                                sat16(round14(ct_ca_reg)), cfg.axis_select);
        end
    end

    assign pos0 = pos0_reg;
    assign pos1 = pos1_reg;
    assign nrm  = nrm_reg;

endmodule

// ----- sv/tube_strip_vertex_generator_core.sv -----
// Top level of the tube strip vertex generator: registers, pipeline control and result serialiser.
//
//  channel  direction  payload
//  s_       in         tdata[7:0] segment_index
//  m_       out        tdata[95:0] pos_x..norm_z, tuser {error, ring_select}, tlast last
//  apb      in/out     eight registers at byte addresses 0 to 28
//
// One index is taken per cycle while the serialiser holds no valid item, into a 38-register
// pipeline (long division for theta, two CORDIC chains of 16 steps, products, then the
// serialiser). Each index yields two transactions, so the output port limits the sustained rate.
// The whole pipeline advances on one enable; a stall at the output holds every stage.
// Reset clears the valid bits and loads the register defaults.
module tube_strip_vertex_generator_core #(
    parameter int MAX_SEGMENTS = tsvg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // segment_index
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
    output logic [95:0] m_tdata,
    // ring_select, error
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int L = tsvg_pkg::PIPE_LAT;

    logic [7:0]      segments_reg;
    tsvg_pkg::cfg_t  cfg_reg;
    logic            en;
    logic            err_in;
    logic            cfg_wr;
    tsvg_pkg::reg_idx_t reg_idx;

    logic            valid_reg [L];
    logic            err_reg   [L];
    tsvg_pkg::angle_t theta_div;
    tsvg_pkg::angle_t theta_dly_reg [tsvg_pkg::THETA_DELAY];
    tsvg_pkg::angle_t norm_angle;
    tsvg_pkg::trig_t st, ct, sa, ca;
    tsvg_pkg::vec3_t pos0, pos1, nrm;

    logic            hold_valid_reg;
    logic            phase_reg;
    logic            hold_err_reg;
    tsvg_pkg::vec3_t pos0_reg, pos1_reg, nrm_reg;
    tsvg_pkg::vec3_t pos_sel;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = tsvg_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segments_reg         <= 8'd8;
            cfg_reg.axis_select  <= 2'd1;
            cfg_reg.x_start      <= '0;
            cfg_reg.r_start      <= '0;
            cfg_reg.x_end        <= 16'sd16384;
            cfg_reg.r_end        <= 16'sd8192;
            cfg_reg.center_y     <= '0;
            cfg_reg.center_z     <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                tsvg_pkg::REG_SEGMENTS:    segments_reg        <= pwdata[7:0];
                tsvg_pkg::REG_AXIS_SELECT: cfg_reg.axis_select <= pwdata[1:0];
                tsvg_pkg::REG_X_START:     cfg_reg.x_start     <= pwdata[15:0];
                tsvg_pkg::REG_R_START:     cfg_reg.r_start     <= pwdata[15:0];
                tsvg_pkg::REG_X_END:       cfg_reg.x_end       <= pwdata[15:0];
                tsvg_pkg::REG_R_END:       cfg_reg.r_end       <= pwdata[15:0];
                tsvg_pkg::REG_CENTER_Y:    cfg_reg.center_y    <= pwdata[15:0];
                tsvg_pkg::REG_CENTER_Z:    cfg_reg.center_z    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tsvg_pkg::REG_SEGMENTS:    prdata = {24'd0, segments_reg};
            tsvg_pkg::REG_AXIS_SELECT: prdata = {30'd0, cfg_reg.axis_select};
            tsvg_pkg::REG_X_START:     prdata = {16'd0, cfg_reg.x_start};
            tsvg_pkg::REG_R_START:     prdata = {16'd0, cfg_reg.r_start};
            tsvg_pkg::REG_X_END:       prdata = {16'd0, cfg_reg.x_end};
            tsvg_pkg::REG_R_END:       prdata = {16'd0, cfg_reg.r_end};
            tsvg_pkg::REG_CENTER_Y:    prdata = {16'd0, cfg_reg.center_y};
            tsvg_pkg::REG_CENTER_Z:    prdata = {16'd0, cfg_reg.center_z};
            default:                   prdata = '0;
        endcase
    end

    // Flag bad configuration or an index past the closing column
    assign err_in = (segments_reg < 8'(tsvg_pkg::MIN_SEGMENTS)) ||
                    (int'(segments_reg) > MAX_SEGMENTS) ||
                    (s_tdata > segments_reg) ||
                    ((cfg_reg.x_start == cfg_reg.x_end) && (cfg_reg.r_start == cfg_reg.r_end));

    // Advance the whole pipeline when the serialiser can take a new item
    assign en       = !hold_valid_reg || (phase_reg && m_tready);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < L; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < L; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            err_reg[0] <= err_in;
            for (int i = 1; i < L; i++) begin
                err_reg[i] <= err_reg[i-1];
            end
        end
    end

    tsvg_theta_div u_div (
        .aclk          (aclk),
        .en            (en),
        .segment_index (s_tdata),
        .segments      (segments_reg),
        .theta         (theta_div)
    );

    // Align theta with the normal angle
    always_ff @(posedge aclk) begin
        if (en) begin
            theta_dly_reg[0] <= theta_div;
            for (int i = 1; i < tsvg_pkg::THETA_DELAY; i++) begin
                theta_dly_reg[i] <= theta_dly_reg[i-1];
            end
        end
    end

    tsvg_vec_cordic u_vec (
        .aclk  (aclk),
        .en    (en),
        .cfg   (cfg_reg),
        .angle (norm_angle)
    );

    tsvg_rot_cordic u_rot_theta (
        .aclk  (aclk),
        .en    (en),
        .angle (theta_dly_reg[tsvg_pkg::THETA_DELAY-1]),
        .sin_q (st),
        .cos_q (ct)
    );

    tsvg_rot_cordic u_rot_norm (
        .aclk  (aclk),
        .en    (en),
        .angle (norm_angle),
        .sin_q (sa),
        .cos_q (ca)
    );

    tsvg_vertex_calc u_calc (
        .aclk (aclk),
        .en   (en),
        .cfg  (cfg_reg),
        .st   (st),
        .ct   (ct),
        .sa   (sa),
        .ca   (ca),
        .pos0 (pos0),
        .pos1 (pos1),
        .nrm  (nrm)
    );

    // Serialiser: hold one item and emit start ring then end ring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end else if (en) begin
            hold_valid_reg <= valid_reg[L-1];
            phase_reg      <= 1'b0;
        end else if (hold_valid_reg && m_tready) begin
            phase_reg      <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hold_err_reg <= err_reg[L-1];
            pos0_reg     <= err_reg[L-1] ? '0 : pos0;
            pos1_reg     <= err_reg[L-1] ? '0 : pos1;
            nrm_reg      <= err_reg[L-1] ? '0 : nrm;
        end
    end

    assign pos_sel  = phase_reg ? pos1_reg : pos0_reg;
    assign m_tvalid = hold_valid_reg;
    assign m_tlast  = phase_reg;
    assign m_tuser  = {hold_err_reg, phase_reg};
    assign m_tdata  = {nrm_reg[2], nrm_reg[1], nrm_reg[0], pos_sel[2], pos_sel[1], pos_sel[0]};

endmodule

// ----- tb/sv/tb_checker.sv -----
// Checker for the tube strip vertex generator: watches all three channels, predicts and compares.
`timescale 1ns / 100ps
module tb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_vertices
);

    typedef struct {
        logic        ring;
        logic [95:0] data;
        logic        last;
        logic        err;
    } vertex_t;

    vertex_t vertex_q[$];

    logic [7:0]  seg_r;
    logic [1:0]  axis_r;
    logic [15:0] xs_r, rs_r, xe_r, re_r, cy_r, cz_r;

    localparam longint ATAN_TBL [16] = '{536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861};

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return shr(a * b + 8192, 14);
    endfunction

    // Rotation CORDIC over a turn-scaled angle
    task automatic turn_sincos(input logic [31:0] z, output longint s, output longint c);
        logic [31:0] zr;
        logic        neg;
        longint      a, x, y, dx, dy;
        neg = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        zr = neg ? z - 32'h8000_0000 : z;
        a = longint'($signed(zr));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (a >= 0) begin
                x -= dx; y += dy; a -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; a += ATAN_TBL[i];
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        c = shr(x + 32768, 16);
        s = shr(y + 32768, 16);
    endtask

    // Vectoring CORDIC giving the slope angle of the surface
    function automatic logic [31:0] slope_turn(longint dr, longint dx);
        longint      x, y, tx, ty;
        logic [31:0] z;
        if (dx < 0) begin
            x = -dx * 16384; y = -dr * 16384; z = 32'h8000_0000;
        end else begin
            x = dx * 16384; y = dr * 16384; z = 0;
        end
        for (int i = 0; i < 16; i++) begin
            tx = shr(y, i);
            ty = shr(x, i);
            if (y > 0) begin
                x += tx; y -= ty; z += 32'(ATAN_TBL[i]);
            end else begin
                x -= tx; y += ty; z -= 32'(ATAN_TBL[i]);
            end
        end
        return z;
    endfunction

    // Work out both ring vertices for one column index
    task automatic predict_column(input logic [7:0] j);
        longint      pos[2][3], nrm[3];
        longint      xs, rs, xe, re, cy, cz, st, ct, sa, ca;
        logic [39:0] num;
        logic [31:0] theta;
        int          ix, iy, iz;
        logic        err;
        vertex_t     v;
        err = (seg_r < tsvg_pkg::MIN_SEGMENTS) || (j > seg_r) ||
              (xs_r == xe_r && rs_r == re_r);
        foreach (pos[k, f]) pos[k][f] = 0;
        foreach (nrm[f]) nrm[f] = 0;
        if (!err) begin
            xs = longint'($signed(xs_r)); rs = longint'($signed(rs_r));
            xe = longint'($signed(xe_r)); re = longint'($signed(re_r));
            cy = longint'($signed(cy_r)); cz = longint'($signed(cz_r));
            num = {j, 32'd0};
            theta = 32'(num / seg_r);
            if (axis_r == tsvg_pkg::AXIS_Y) begin
                ix = 1; iy = 2; iz = 0;
            end else if (axis_r == tsvg_pkg::AXIS_Z) begin
                ix = 2; iy = 0; iz = 1;
            end else begin
                ix = 0; iy = 1; iz = 2;
            end
            turn_sincos(theta, st, ct);
            turn_sincos(slope_turn(re - rs, xe - xs), sa, ca);
            pos[0][ix] = xs;
            pos[0][iy] = clip16(cy + qmul(rs, st));
            pos[0][iz] = clip16(cz + qmul(rs, ct));
            pos[1][ix] = xe;
            pos[1][iy] = clip16(cy + qmul(re, st));
            pos[1][iz] = clip16(cz + qmul(re, ct));
            nrm[ix] = clip16(-sa);
            nrm[iy] = clip16(qmul(st, ca));
            nrm[iz] = clip16(qmul(ct, ca));
        end
        for (int k = 0; k < 2; k++) begin
            v.ring = k[0];
            v.last = k[0];
            v.err  = err;
            v.data = {16'(nrm[2]), 16'(nrm[1]), 16'(nrm[0]),
                      16'(pos[k][2]), 16'(pos[k][1]), 16'(pos[k][0])};
            vertex_q.push_back(v);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        vertex_t e;
        if (!aresetn) begin
            seg_r <= 8'd8; axis_r <= 2'd1;
            xs_r <= 16'd0; rs_r <= 16'd0; xe_r <= 16'd16384; re_r <= 16'd8192;
            cy_r <= 16'd0; cz_r <= 16'd0;
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (tsvg_pkg::reg_idx_t'(paddr[4:2]))
                    tsvg_pkg::REG_SEGMENTS:    seg_r  <= pwdata[7:0];
                    tsvg_pkg::REG_AXIS_SELECT: axis_r <= pwdata[1:0];
                    tsvg_pkg::REG_X_START:     xs_r   <= pwdata[15:0];
                    tsvg_pkg::REG_R_START:     rs_r   <= pwdata[15:0];
                    tsvg_pkg::REG_X_END:       xe_r   <= pwdata[15:0];
                    tsvg_pkg::REG_R_END:       re_r   <= pwdata[15:0];
                    tsvg_pkg::REG_CENTER_Y:    cy_r   <= pwdata[15:0];
                    tsvg_pkg::REG_CENTER_Z:    cz_r   <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_column(s_tdata);
            // Compare each result transaction with the oldest expected vertex
            if (m_tvalid && m_tready) begin
                if (vertex_q.size() == 0) begin
                    report_mismatch("unexpected result transaction");
                end else begin
                    e = vertex_q.pop_front();
                    if (m_tdata !== e.data)
                        report_mismatch($sformatf("tdata %h expected %h", m_tdata, e.data));
                    if (m_tuser[0] !== e.ring)
                        report_mismatch($sformatf("ring_select %b expected %b",
                                                  m_tuser[0], e.ring));
                    if (m_tuser[1] !== e.err)
                        report_mismatch($sformatf("error %b expected %b", m_tuser[1], e.err));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("tlast %b expected %b", m_tlast, e.last));
                end
            end
        end
        pending_vertices <= vertex_q.size();
    end
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top: clock, reset, register phases, index stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast, m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending_vertices;
    logic [7:0]  seg_now = 8'd8;
    bit          rx_busy = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tube_strip_vertex_generator_core u_top (.*);

    tb_checker u_chk (.*);

    // Result side back-pressure: random stall per transaction, with idle-free phases
    always @(posedge aclk) begin
        int gap;
        if (aresetn && (!m_tready || m_tvalid)) begin
            gap = rx_busy ? $urandom_range(0, 3) : 0;
            if (gap == 0) m_tready <= 1'b1;
            else begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input tsvg_pkg::reg_idx_t idx, input logic [15:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {16'(0), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
        if (idx == tsvg_pkg::REG_SEGMENTS) seg_now = val[7:0];
    endtask

    // Hold tvalid high across back-to-back transactions, drop it only for idle cycles
    task automatic send_index(input logic [7:0] j, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= j;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait until the pipeline has emptied before touching registers
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_vertices != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Mostly valid indices, some beyond the segment count
    function automatic logic [7:0] pick_index;
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(0, seg_now));
    endfunction

    task automatic random_config;
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) write_reg(tsvg_pkg::REG_SEGMENTS, 16'($urandom_range(3, 24)));
        else if (k < 8) write_reg(tsvg_pkg::REG_SEGMENTS, 16'($urandom_range(3, 255)));
        else write_reg(tsvg_pkg::REG_SEGMENTS, 16'($urandom_range(0, 3)));
        write_reg(tsvg_pkg::REG_AXIS_SELECT, 16'($urandom_range(0, 3)));
        write_reg(tsvg_pkg::REG_X_START, 16'($urandom));
        write_reg(tsvg_pkg::REG_R_START,
                  ($urandom_range(0, 3) == 0) ? 16'(0) : 16'($urandom));
        write_reg(tsvg_pkg::REG_X_END, 16'($urandom));
        write_reg(tsvg_pkg::REG_R_END, 16'($urandom));
        write_reg(tsvg_pkg::REG_CENTER_Y,
                  ($urandom_range(0, 1) == 0) ? 16'(0) : 16'($urandom));
        write_reg(tsvg_pkg::REG_CENTER_Z,
                  ($urandom_range(0, 1) == 0) ? 16'(0) : 16'($urandom));
        if ($urandom_range(0, 9) == 0) write_reg(tsvg_pkg::REG_X_END, 16'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, index extremes, closing column
        send_index(8'd0, 0);
        send_index(8'd8, 0);
        send_index(8'd9, 0);
        send_index(8'd255, 0);
        send_index(8'd3, 1);
        drain();
        // Degenerate surface, too few segments, extreme registers
        write_reg(tsvg_pkg::REG_X_END, 16'd0);
        write_reg(tsvg_pkg::REG_R_END, 16'd0);
        send_index(8'd1, 0);
        drain();
        write_reg(tsvg_pkg::REG_SEGMENTS, 16'd2);
        write_reg(tsvg_pkg::REG_X_END, 16'h7fff);
        write_reg(tsvg_pkg::REG_R_END, 16'h8000);
        send_index(8'd0, 0);
        drain();
        write_reg(tsvg_pkg::REG_SEGMENTS, 16'd255);
        write_reg(tsvg_pkg::REG_AXIS_SELECT, 16'd2);
        write_reg(tsvg_pkg::REG_X_START, 16'h7fff);
        write_reg(tsvg_pkg::REG_R_START, 16'h7fff);
        write_reg(tsvg_pkg::REG_X_END, 16'h8000);
        write_reg(tsvg_pkg::REG_R_END, 16'h7fff);
        write_reg(tsvg_pkg::REG_CENTER_Y, 16'h7fff);
        write_reg(tsvg_pkg::REG_CENTER_Z, 16'h8000);
        send_index(8'd0, 0);
        send_index(8'd64, 0);
        send_index(8'd170, 0);
        send_index(8'd255, 0);
        drain();
        write_reg(tsvg_pkg::REG_SEGMENTS, 16'd3);
        write_reg(tsvg_pkg::REG_AXIS_SELECT, 16'd3);
        write_reg(tsvg_pkg::REG_R_START, 16'h8000);
        write_reg(tsvg_pkg::REG_CENTER_Y, 16'h8000);
        write_reg(tsvg_pkg::REG_CENTER_Z, 16'h7fff);
        for (int j = 0; j <= 4; j++) send_index(8'(j), 0);
        drain();
        write_reg(tsvg_pkg::REG_AXIS_SELECT, 16'd0);
        write_reg(tsvg_pkg::REG_SEGMENTS, 16'd0);
        send_index(8'd0, 0);
        drain();

        // Random phases, some without idling
        for (int p = 0; p < 34; p++) begin
            bit gaps;
            random_config();
            gaps = (p % 4) != 3;
            rx_busy = gaps;
            for (int n = 0; n < 50; n++) send_index(pick_index(), gaps);
            drain();
        end
        rx_busy = 1'b1;

        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- tube_strip_vertex_generator_core.f -----
sv/tsvg_pkg.sv
sv/tsvg_theta_div.sv
sv/tsvg_vec_cordic.sv
sv/tsvg_rot_cordic.sv
sv/tsvg_vertex_calc.sv
sv/tube_strip_vertex_generator_core.sv
tb/sv/tb_checker.sv
tb/sv/tb_top.sv
